// ----- sv/fss_pkg.sv -----
// Shared types, constants and command codes of the fair-share task scheduler.
package fss_pkg;

  localparam int SLOTS = 16;
  localparam int SLOT_W = $clog2(SLOTS);

  localparam logic [16:0] DEFAULT_WEIGHT = 17'd1024;
  localparam logic [4:0] COUNT_MAX = 5'd31;
  localparam logic [20:0] LOAD_MAX = 21'h1FFFFF;

  typedef enum logic [2:0] {
    CMD_ENQUEUE = 3'd0,
    CMD_DEQUEUE = 3'd1,
    CMD_TICK = 3'd2,
    CMD_PICK = 3'd3,
    CMD_CHECK = 3'd4,
    CMD_SET_STATE = 3'd5
  } cmd_t;

  localparam logic [2:0] ST_RUNNING = 3'd0;
  localparam logic [2:0] ST_READY = 3'd1;
  localparam logic [2:0] ST_BLOCKED = 3'd2;
  localparam logic [2:0] ST_DEAD = 3'd3;
  localparam logic [2:0] ST_OTHER = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the input transaction
    logic scan_start;  // clear the running minimum
    logic scan_step;   // compare one slot against the minimum
    logic enq;         // commit an enqueue
    logic deq;         // commit a dequeue
    logic set_state;   // commit a state write
    logic cur_first;   // current takes the scan result
    logic purge;       // remove the dead scan winner
    logic pick_done;   // current takes the scan result or none
    logic div_start;   // start the serial divider
    logic div_step;    // one quotient bit
    logic mul_step;    // one multiplier step
    logic tick_commit; // write charged runtime
    logic chk_commit;  // compare share used and need
  } fss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] cmd;
    logic scan_last;
    logic div_last;
    logic mul_last;
    logic found;
    logic found_dead;
    logic count_zero;
    logic count_one;
    logic cur_valid;
    logic cur_is_slot;
    logic slot_queued;
    logic chk_ok;
  } fss_stat_t;

endpackage

// ----- sv/fss_ctrl.sv -----
// Controller state machine of the fair-share task scheduler.
module fss_ctrl import fss_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic out_free,
  input  fss_stat_t stat,
  output fss_cmd_t cmd,
  output logic busy,
  output logic done
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_DEQ_SCAN, S_DEQ_FIX, S_PICK_SCAN, S_PICK_EVAL,
    S_TICK_DIV, S_TICK_COMMIT, S_CHK_MUL, S_CHK_DIV, S_CHK_COMMIT, S_DONE
  } state_t;

  state_t state;

  assign busy = (state != S_IDLE);

  // Command decode per state.
  always_comb begin
    cmd = '0;
    done = 1'b0;
    case (state)
      S_IDLE: cmd.load = in_fire;
      S_DECODE: begin
        case (stat.cmd)
          CMD_ENQUEUE: cmd.enq = 1'b1;
          CMD_DEQUEUE: begin
            cmd.deq = 1'b1;
            cmd.scan_start = 1'b1;
          end
          CMD_TICK: cmd.div_start = 1'b1;
          CMD_PICK: cmd.scan_start = 1'b1;
          CMD_CHECK: cmd.div_start = 1'b1;
          CMD_SET_STATE: cmd.set_state = 1'b1;
          default: ;
        endcase
      end
      S_DEQ_SCAN, S_PICK_SCAN: cmd.scan_step = 1'b1;
      S_DEQ_FIX: cmd.cur_first = 1'b1;
      S_PICK_EVAL: begin
        if (stat.found && stat.found_dead && !stat.count_one) begin
          cmd.purge = 1'b1;
          cmd.scan_start = 1'b1;
        end else if (stat.found && stat.found_dead) begin
          cmd.purge = 1'b1;
          cmd.pick_done = 1'b1;
        end else begin
          cmd.pick_done = 1'b1;
        end
      end
      S_TICK_DIV, S_CHK_DIV: cmd.div_step = 1'b1;
      S_TICK_COMMIT: cmd.tick_commit = 1'b1;
      S_CHK_MUL: cmd.mul_step = 1'b1;
      S_CHK_COMMIT: cmd.chk_commit = 1'b1;
      S_DONE: done = out_free;
      default: ;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (in_fire) state <= S_DECODE;
        S_DECODE: begin
          case (stat.cmd)
            CMD_DEQUEUE: state <= (stat.slot_queued && stat.cur_valid && stat.cur_is_slot) ?
                                  S_DEQ_SCAN : S_DONE;
            CMD_TICK: state <= stat.cur_valid ? S_TICK_DIV : S_DONE;
            CMD_PICK: state <= stat.count_zero ? S_PICK_EVAL : S_PICK_SCAN;
            CMD_CHECK: state <= stat.chk_ok ? S_CHK_MUL : S_DONE;
            default: state <= S_DONE;
          endcase
        end
        S_DEQ_SCAN: if (stat.scan_last) state <= S_DEQ_FIX;
        S_DEQ_FIX: state <= S_DONE;
        S_PICK_SCAN: if (stat.scan_last) state <= S_PICK_EVAL;
        S_PICK_EVAL: begin
          if (stat.found && stat.found_dead && !stat.count_one) state <= S_PICK_SCAN;
          else state <= S_DONE;
        end
        S_TICK_DIV: if (stat.div_last) state <= S_TICK_COMMIT;
        S_TICK_COMMIT: state <= S_DONE;
        S_CHK_MUL: if (stat.mul_last) state <= S_CHK_DIV;
        S_CHK_DIV: if (stat.div_last) state <= S_CHK_COMMIT;
        S_CHK_COMMIT: state <= S_DONE;
        S_DONE: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/fss_datapath.sv -----
// Task table, scan comparator, serial multiplier and divider of the scheduler.
module fss_datapath import fss_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  fss_cmd_t cmd,
  output fss_stat_t stat,
  input  logic [2:0] in_cmd,
  input  logic [3:0] in_slot,
  input  logic [16:0] in_weight,
  input  logic [2:0] in_state,
  input  logic [31:0] in_elapsed,
  input  logic cfg_we,
  input  logic [31:0] cfg_data,
  output logic [3:0] cur_slot_o,
  output logic cur_valid_o,
  output logic resched_o,
  output logic [4:0] count_o,
  output logic [20:0] load_o
);

  // Table and scalar state.
  logic [63:0] vrt [SLOTS];
  logic [16:0] wgt [SLOTS];
  logic [2:0] sst [SLOTS];
  logic [SLOTS-1:0] queued;
  logic [31:0] used [SLOTS];
  logic [63:0] floor_rt;
  logic [SLOT_W-1:0] cur_slot;
  logic cur_valid;
  logic [4:0] count;
  logic [20:0] load;
  logic [31:0] period;
  logic resched;

  // Captured transaction.
  logic [2:0] t_cmd;
  logic [3:0] t_slot;
  logic [16:0] t_weight;
  logic [2:0] t_state;
  logic [31:0] t_elapsed;

  // Scan.
  logic [SLOT_W:0] scan_idx;
  logic [SLOT_W-1:0] best;
  logic best_found;
  logic [63:0] best_vrt;

  // Serial arithmetic: 64-bit dividend, 21-bit divisor.
  logic [63:0] quo;
  logic [21:0] rem;
  logic [20:0] divisor;
  logic [6:0] div_cnt;
  logic [63:0] prod;
  logic [31:0] mcand;
  logic [5:0] mul_cnt;
  logic [21:0] mul_base;
  logic [63:0] mul_acc;

  logic slot_ok;
  logic [SLOT_W-1:0] ts;
  logic [SLOT_W-1:0] scan_i;
  logic [16:0] ts_w;
  logic [16:0] cur_w;
  logic [16:0] best_w;
  logic [16:0] enq_w;
  logic [21:0] rem_sh;
  logic [21:0] load_add;
  logic [4:0] count_dec;
  logic [20:0] load_sub_cur;
  logic [20:0] load_sub_best;
  logic [32:0] used_add;
  logic [63:0] vrt_new;
  logic any_q;

  assign slot_ok = ({28'd0, t_slot} < 32'(SLOTS));
  assign ts = t_slot[SLOT_W-1:0];
  assign scan_i = scan_idx[SLOT_W-1:0];
  assign ts_w = (wgt[ts] == '0) ? DEFAULT_WEIGHT : wgt[ts];
  assign cur_w = (wgt[cur_slot] == '0) ? DEFAULT_WEIGHT : wgt[cur_slot];
  assign best_w = (wgt[best] == '0) ? DEFAULT_WEIGHT : wgt[best];
  assign enq_w = (t_weight == '0) ? DEFAULT_WEIGHT : t_weight;
  assign any_q = |queued;
  assign rem_sh = {rem[20:0], quo[63]};
  assign load_add = {1'b0, load} + {5'd0, enq_w};
  assign count_dec = (count != '0) ? count - 5'd1 : count;
  assign load_sub_cur = (load > {4'd0, ts_w}) ? load - {4'd0, ts_w} : '0;
  assign load_sub_best = (load > {4'd0, best_w}) ? load - {4'd0, best_w} : '0;
  assign used_add = {1'b0, used[cur_slot]} + {1'b0, t_elapsed};
  assign vrt_new = vrt[cur_slot] + quo;

  // Count times weight is the multiplicand; the period is shifted in bit by bit.
  assign mul_base = {17'd0, count} * {5'd0, cur_w};
  assign mul_acc = prod + ({42'd0, mul_base} << mul_cnt);

  // Status to the controller.
  always_comb begin
    stat.cmd = t_cmd;
    stat.scan_last = (scan_idx == (SLOT_W+1)'(SLOTS - 1));
    stat.div_last = (div_cnt == 7'd63);
    stat.mul_last = (mul_cnt == 6'd31);
    stat.found = best_found;
    stat.found_dead = (sst[best] == ST_DEAD);
    stat.count_zero = (count == '0);
    stat.count_one = (count <= 5'd1);
    stat.cur_valid = cur_valid;
    stat.cur_is_slot = (cur_slot == ts);
    stat.slot_queued = slot_ok && queued[ts];
    stat.chk_ok = (load != '0) && (count != '0) && cur_valid;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) period <= 32'd10;
    else if (cfg_we) period <= cfg_data;
  end

  // Transaction capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_cmd <= in_cmd;
      t_slot <= in_slot;
      t_weight <= in_weight;
      t_state <= in_state;
      t_elapsed <= in_elapsed;
    end
  end

  // Minimum scan, one slot a cycle.
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx <= '0;
      best_found <= 1'b0;
      best <= '0;
      best_vrt <= '0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + 1'b1;
      if (queued[scan_i] && (!best_found || vrt[scan_i] < best_vrt)) begin
        best <= scan_i;
        best_vrt <= vrt[scan_i];
        best_found <= 1'b1;
      end
    end
  end

  // Shift-add multiplier and restoring divider.
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      mul_cnt <= '0;
      div_cnt <= '0;
      rem <= '0;
      if (t_cmd == CMD_TICK) begin
        quo <= {22'd0, t_elapsed, 10'd0};
        divisor <= {4'd0, cur_w};
      end else begin
        prod <= '0;
        mcand <= period;
        divisor <= load;
        quo <= '0;
      end
    end else if (cmd.mul_step) begin
      mul_cnt <= mul_cnt + 1'b1;
      if (mcand[0]) prod <= mul_acc;
      mcand <= mcand >> 1;
      if (mul_cnt == 6'd31) begin
        // Last step: the full product becomes the dividend.
        quo <= mcand[0] ? mul_acc : prod;
      end
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
      if (rem_sh >= {1'b0, divisor}) begin
        rem <= rem_sh - {1'b0, divisor};
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  // Table and scalar updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      queued <= '0;
      floor_rt <= '0;
      cur_slot <= '0;
      cur_valid <= 1'b0;
      count <= '0;
      load <= '0;
      resched <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        vrt[i] <= '0;
        wgt[i] <= '0;
        sst[i] <= ST_OTHER;
        used[i] <= '0;
      end
    end else begin
      if (cmd.load) resched <= 1'b0;
      if (cmd.enq && slot_ok && !queued[ts] &&
          (sst[ts] == ST_RUNNING || sst[ts] == ST_READY)) begin
        if (any_q && vrt[ts] < floor_rt) vrt[ts] <= floor_rt;
        wgt[ts] <= enq_w;
        queued[ts] <= 1'b1;
        if (count < COUNT_MAX) count <= count + 5'd1;
        load <= load_add[21] ? LOAD_MAX : load_add[20:0];
        if (!cur_valid) begin
          cur_slot <= ts;
          cur_valid <= 1'b1;
        end
      end
      if (cmd.deq && slot_ok && queued[ts]) begin
        queued[ts] <= 1'b0;
        if (sst[ts] == ST_RUNNING || sst[ts] == ST_READY || sst[ts] == ST_BLOCKED) begin
          count <= count_dec;
          load <= load_sub_cur;
        end
      end
      if (cmd.set_state && slot_ok) sst[ts] <= t_state;
      if (cmd.cur_first) begin
        cur_valid <= best_found;
        cur_slot <= best_found ? best : '0;
      end
      if (cmd.purge) begin
        queued[best] <= 1'b0;
        count <= count_dec;
        load <= load_sub_best;
      end
      if (cmd.pick_done) begin
        if (best_found && sst[best] != ST_DEAD) begin
          cur_valid <= 1'b1;
          cur_slot <= best;
        end else begin
          cur_valid <= 1'b0;
          cur_slot <= '0;
        end
      end
      if (cmd.tick_commit) begin
        vrt[cur_slot] <= vrt_new;
        used[cur_slot] <= used_add[32] ? 32'hFFFF_FFFF : used_add[31:0];
        if (vrt_new < floor_rt) floor_rt <= vrt_new;
      end
      if (cmd.chk_commit) begin
        if ({32'd0, used[cur_slot]} >= quo) begin
          used[cur_slot] <= '0;
          resched <= 1'b1;
        end
      end
    end
  end

  assign cur_slot_o = cur_valid ? 4'(cur_slot) : 4'd0;
  assign cur_valid_o = cur_valid;
  assign resched_o = resched;
  assign count_o = count;
  assign load_o = load;

endmodule

// ----- sv/fair_share_task_scheduler.sv -----
// Top level of the fair-share task scheduler.
// Use: an upstream block offers one command transaction on the input
// channel (in_valid / in_ready) carrying cmd, task_slot, task_weight,
// new_state and elapsed. Exactly one result transaction follows on the
// output channel (out_valid / out_ready) with the current slot, its valid
// flag, the reschedule flag, the runnable count and the load sum.
// Commands are handled one at a time by a controller and a datapath.
// Enqueue, set state and other dequeues go straight to the result; a
// dequeue of the current task runs a 16-slot minimum scan, one slot a
// cycle; pick runs that scan unless nothing is queued, and scans again
// for each dead task purged while others remain; tick runs a 64-step
// serial divider; check a 32-step multiplier and a 64-step divider. The
// controller goes idle as the result is registered, and only once the
// result register is free: a stalled receiver holds off the next command.
// The user writes period_ticks through cfg_we / cfg_data while idle;
// the block does not enforce this. Reset clears the task table: all
// slots empty, state other, no current task, period 10.
module fair_share_task_scheduler import fss_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [2:0] cmd,
  input  logic [3:0] task_slot,
  input  logic [16:0] task_weight,
  input  logic [2:0] new_state,
  input  logic [31:0] elapsed,
  output logic out_valid,
  input  logic out_ready,
  output logic [3:0] chosen_slot,
  output logic chosen_valid,
  output logic reschedule,
  output logic [4:0] queued_count,
  output logic [20:0] weight_sum,
  input  logic cfg_we,
  input  logic [31:0] cfg_data
);

  fss_cmd_t dp_cmd;
  fss_stat_t dp_stat;
  logic busy;
  logic done;
  logic in_fire;
  logic out_free;
  logic [3:0] r_slot;
  logic r_valid;
  logic r_resched;
  logic [4:0] r_count;
  logic [20:0] r_load;

  assign out_free = !out_valid || out_ready;
  assign in_ready = !busy;
  assign in_fire = in_valid && in_ready;

  fss_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_free(out_free),
    .stat(dp_stat), .cmd(dp_cmd), .busy(busy), .done(done)
  );

  fss_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(dp_cmd), .stat(dp_stat),
    .in_cmd(cmd), .in_slot(task_slot), .in_weight(task_weight),
    .in_state(new_state), .in_elapsed(elapsed),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .cur_slot_o(r_slot), .cur_valid_o(r_valid), .resched_o(r_resched),
    .count_o(r_count), .load_o(r_load)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      chosen_slot <= r_slot;
      chosen_valid <= r_valid;
      reschedule <= r_resched;
      queued_count <= r_count;
      weight_sum <= r_load;
    end
  end

  // A result never overwrites one still waiting.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !done) else $error("result overrun");

  // A transaction, taken only while the controller is idle, starts it.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> busy) else $error("controller did not start");

  // No current task means a zero slot.
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !chosen_valid |-> chosen_slot == 4'd0) else $error("stray slot");

endmodule
